// ===== rtl/core/bfha_pkg.sv =====
// Shared types, constants and controller/datapath interface of the heap allocator.
`default_nettype none
package bfha_pkg;

    // heap geometry and header layout
    localparam int HEAP_BYTES_DEF = 4096;
    localparam int HDR_BYTES      = 8;
    localparam int NEED_W         = 14;

    // configuration
    localparam logic [7:0] SLACK_RESET     = 8'd32;
    localparam logic       REG_SPLIT_SLACK = 1'b0;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    // operation codes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [12:0] request_bytes;
        logic [11:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [11:0] data_offset;
        logic [1:0]  status;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic walk;
        logic wr_alloc;
        logic wr_split;
        logic free_fin;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero_req;
        logic alloc_hit;
        logic free_hit;
        logic walk_done;
        logic split;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/core/bfha_ctrl.sv =====
// Sequencer for the chunk walk, header writes and result hand-off.
`default_nettype none
module bfha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bfha_pkg::t_sts i_sts,
    output bfha_pkg::t_cmd     o_cmd
);
    import bfha_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_WALK     = 3'd1;
    localparam logic [2:0] S_WR_ALLOC = 3'd2;
    localparam logic [2:0] S_WR_SPLIT = 3'd3;
    localparam logic [2:0] S_FREE_FIN = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    // decide next state and issue commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = i_sts.zero_req ? S_FINISH : S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.alloc_hit) begin
                    n_state = S_WR_ALLOC;
                end else if (i_sts.free_hit) begin
                    n_state = S_FREE_FIN;
                end else if (i_sts.walk_done) begin
                    n_state = S_FINISH;
                end
            end
            S_WR_ALLOC: begin
                o_cmd.wr_alloc = 1'b1;
                n_state        = i_sts.split ? S_WR_SPLIT : S_FINISH;
            end
            S_WR_SPLIT: begin
                o_cmd.wr_split = 1'b1;
                n_state        = S_FINISH;
            end
            S_FREE_FIN: begin
                o_cmd.free_fin = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bfha_dp.sv =====
// Header memory, chunk walk registers and result register of the heap allocator.
`default_nettype none
module bfha_dp #(
    parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire bfha_pkg::t_req i_in_data,
    input  wire logic [7:0]     i_slack,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output bfha_pkg::t_res      o_out_data,
    input  wire bfha_pkg::t_cmd i_cmd,
    output bfha_pkg::t_sts      o_sts
);
    import bfha_pkg::*;

    localparam int SPAN  = (HEAP_BYTES + 3) / 4 * 4;
    localparam int WORDS = SPAN / 4;
    localparam int P     = $clog2(SPAN + 1);
    localparam int IW    = $clog2(WORDS);
    localparam int EW    = P + 1;
    localparam int CW    = (P > NEED_W) ? P : NEED_W;

    // header store: free mark over chunk size
    logic [EW-1:0] r_mem [WORDS];
    logic [EW-1:0] r_q;
    logic          r_q_w0;
    logic          r_w0_valid;

    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [EW-1:0] wr_data;

    // request and walk state
    t_req          r_req;
    logic [NEED_W-1:0] r_need;
    logic [P-1:0]  r_pos;
    logic          r_found;
    logic [P-1:0]  r_best_pos;
    logic [P-1:0]  r_best_sz;
    logic          r_have_prev;
    logic [P-1:0]  r_prev_pos;
    logic [EW-1:0] r_prev_h;
    logic [P-1:0]  r_hit_pos;
    logic [P-1:0]  r_cur_sz;
    logic          r_nxt_in;
    logic [1:0]    r_st;
    logic [11:0]   r_off;
    logic          r_out_valid;
    t_res          r_out;

    logic [EW-1:0]     h;
    logic [P-1:0]      h_sz;
    logic              h_fr;
    logic [P:0]        nxt;
    logic              last;
    logic              hit;
    logic              fits;
    logic              is_free_op;
    logic [NEED_W-1:0] start_need;
    logic [CW-1:0]     best_diff;
    logic              split;
    logic              nf;
    logic              pf;
    logic [P-1:0]      n_total;
    logic [P-1:0]      split_pos;
    logic [P-1:0]      best_off;

    // word zero reads as one free chunk spanning the heap until first written
    assign h    = (r_q_w0 && !r_w0_valid) ? {1'b1, P'(SPAN)} : r_q;
    assign h_sz = h[P-1:0];
    assign h_fr = h[P];

    // decode the chunk just read
    assign nxt  = {1'b0, r_pos} + {1'b0, h_sz};
    assign last = (h_sz == '0) || (nxt >= (P+1)'(SPAN));
    assign hit  = (CW'(r_pos) + CW'(HDR_BYTES)) == CW'(r_req.free_offset);
    assign fits = h_fr && (CW'(h_sz) >= CW'(r_need)) &&
                  (!r_found || (h_sz < r_best_sz));
    assign is_free_op = (r_req.mode == MODE_FREE);

    assign start_need = ((NEED_W'(i_in_data.request_bytes) + NEED_W'(3)) &
                         ~NEED_W'(3)) + NEED_W'(HDR_BYTES);

    assign best_diff = CW'(r_best_sz) - CW'(r_need);
    assign split     = best_diff > CW'(i_slack);
    assign split_pos = r_best_pos + P'(r_need);
    assign best_off  = r_best_pos + P'(HDR_BYTES);

    // merge with free neighbors on release
    assign nf      = r_nxt_in && h_fr;
    assign pf      = r_have_prev && r_prev_h[P];
    assign n_total = (pf ? r_prev_h[P-1:0] : '0) + r_cur_sz + (nf ? h_sz : '0);

    // status toward the controller
    always_comb begin
        o_sts           = '0;
        o_sts.zero_req  = (i_in_data.mode == MODE_ALLOC) &&
                          (i_in_data.request_bytes == '0);
        o_sts.alloc_hit = !is_free_op && last && (r_found || fits);
        o_sts.free_hit  = is_free_op && hit && !h_fr;
        o_sts.walk_done = is_free_op ? (hit || last) : last;
        o_sts.split     = split;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = '0;
        if (i_cmd.start) begin
            rd_en = 1'b1;
        end
        if (i_cmd.walk && !last) begin
            rd_en  = 1'b1;
            rd_idx = nxt[IW+1:2];
        end
        if (i_cmd.wr_alloc) begin
            wr_en   = 1'b1;
            wr_idx  = r_best_pos[IW+1:2];
            wr_data = {1'b0, split ? P'(r_need) : r_best_sz};
        end
        if (i_cmd.wr_split) begin
            wr_en   = 1'b1;
            wr_idx  = split_pos[IW+1:2];
            wr_data = {1'b1, P'(best_diff)};
        end
        if (i_cmd.free_fin) begin
            wr_en   = 1'b1;
            wr_idx  = pf ? r_prev_pos[IW+1:2] : r_hit_pos[IW+1:2];
            wr_data = {1'b1, n_total};
        end
    end

    // write and read the header store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_q    <= r_mem[rd_idx];
            r_q_w0 <= (rd_idx == '0);
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en && (wr_idx == '0)) begin
                r_w0_valid <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // advance the walk and build the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req       <= i_in_data;
            r_need      <= start_need;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_off       <= '0;
            r_st        <= o_sts.zero_req ? ST_BAD_SIZE : ST_OK;
        end
        if (i_cmd.walk) begin
            r_pos <= nxt[P-1:0];
            if (!is_free_op) begin
                if (fits) begin
                    r_found    <= 1'b1;
                    r_best_pos <= r_pos;
                    r_best_sz  <= h_sz;
                end
                if (last && !(r_found || fits)) begin
                    r_st <= ST_NO_FIT;
                end
            end else if (hit) begin
                r_hit_pos <= r_pos;
                r_cur_sz  <= h_sz;
                r_nxt_in  <= !last;
                if (h_fr) begin
                    r_st <= ST_BAD_FREE;
                end
            end else begin
                r_prev_pos  <= r_pos;
                r_prev_h    <= h;
                r_have_prev <= 1'b1;
                if (last) begin
                    r_st <= ST_BAD_FREE;
                end
            end
        end
        if (i_cmd.wr_alloc) begin
            r_off <= best_off[11:0];
        end
        if (i_cmd.out_load) begin
            r_out.data_offset <= r_off;
            r_out.status      <= r_st;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// ===== rtl/core/best_fit_heap_allocator.sv =====
// Top level of the best-fit heap allocator: register port, controller and datapath.
// An allocate walks every chunk, then, if one fits, writes the allocated header and, on a
// split, the remainder's header; a free walks up to the freed chunk and, if in use,
// writes the merged header. The walk reads one header per cycle from the header memory.
// One request at a time: the input stalls until the result of the last one is loaded.
// Reset: synchronous active low; the heap becomes one free chunk, split_slack becomes 32,
// no clearing pass is needed.
`default_nettype none
module best_fit_heap_allocator #(
    parameter int HEAP_BYTES = bfha_pkg::HEAP_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire bfha_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output bfha_pkg::t_res      o_out_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bfha_pkg::*;

    logic [7:0] r_slack;
    t_cmd       cmd;
    t_sts       sts;

    // hold the split slack register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slack <= SLACK_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SPLIT_SLACK)) begin
            r_slack <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPLIT_SLACK) ? {24'd0, r_slack} : 32'd0;

    bfha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_slack     (r_slack),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire

// ===== rtl/core/bfha_chk.sv =====
// Port-level checks of the heap allocator, bound to the top level.
`default_nettype none
module bfha_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire bfha_pkg::t_req i_in_data,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire bfha_pkg::t_res o_out_data,
    input wire logic           pready
);
    import bfha_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // one request in flight: an accepted request closes the input
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a request");

    // failed requests and frees report a zero offset
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.data_offset == '0)
        else $error("nonzero offset on error");

    // no result right after reset, register port always ready
    a_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid && pready)
        else $error("result or wait state after reset");

endmodule

bind best_fit_heap_allocator bfha_chk u_chk (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the best-fit heap allocator with a behavioral heap predictor.
`default_nettype none
module tb;
    import bfha_pkg::*;

    localparam int HEAP  = 4096;
    localparam int WORDS = HEAP / 4;
    localparam int FREE_BIT = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_req        i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_res        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    best_fit_heap_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state: one header per heap word, free mark in bit 24
    logic [24:0] heap_hdr [WORDS];
    logic [7:0]  slack_bytes;

    t_req request_fifo [$];
    t_res expected_results [$];
    int   error_count;
    int   send_idle_pct;
    int   stall_pct;
    int   hold_cycles;
    bit   in_accepted;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // timeout
    initial begin
        #40000000;
        $display("best_fit_heap_allocator regression: fail");
        $finish;
    end

    function automatic void heap_reset();
        for (int w = 0; w < WORDS; w++) heap_hdr[w] = '0;
        heap_hdr[0] = {1'b1, 24'(HEAP)};
        slack_bytes = SLACK_RESET;
    endfunction

    function automatic t_res heap_alloc(logic [12:0] req);
        t_res r;
        int need, p, best_p, best_sz, sz;
        bit found;
        r.data_offset = '0;
        found = 0;
        best_p = 0;
        best_sz = 0;
        if (req == 0) begin
            r.status = ST_BAD_SIZE;
            return r;
        end
        need = ((int'(req) + 3) & ~3) + HDR_BYTES;
        p = 0;
        while (p < HEAP) begin
            sz = int'(heap_hdr[(p >> 2) % WORDS][23:0]);
            if (sz == 0) break;
            if (heap_hdr[(p >> 2) % WORDS][FREE_BIT] && sz >= need
                && (!found || sz < best_sz)) begin
                found = 1;
                best_p = p;
                best_sz = sz;
            end
            p += sz;
        end
        if (!found) begin
            r.status = ST_NO_FIT;
            return r;
        end
        if (best_sz - need <= int'(slack_bytes)) begin
            heap_hdr[(best_p >> 2) % WORDS] = {1'b0, 24'(best_sz)};
        end else begin
            heap_hdr[(best_p >> 2) % WORDS] = {1'b0, 24'(need)};
            heap_hdr[((best_p + need) >> 2) % WORDS] = {1'b1, 24'(best_sz - need)};
        end
        r.data_offset = 12'(best_p + HDR_BYTES);
        r.status = ST_OK;
        return r;
    endfunction

    function automatic t_res heap_release(logic [11:0] target);
        t_res r;
        int p, prv, sz, nxt, total;
        bit have_prv, found, prv_free, nxt_free;
        r.data_offset = '0;
        r.status = ST_BAD_FREE;
        p = 0; prv = 0; sz = 0; have_prv = 0; found = 0;
        while (p < HEAP) begin
            sz = int'(heap_hdr[(p >> 2) % WORDS][23:0]);
            if (sz == 0) break;
            if (p + HDR_BYTES == int'(target)) begin
                found = 1;
                break;
            end
            prv = p;
            have_prv = 1;
            p += sz;
        end
        if (!found || heap_hdr[(p >> 2) % WORDS][FREE_BIT]) return r;
        nxt = p + sz;
        nxt_free = nxt < HEAP && heap_hdr[(nxt >> 2) % WORDS][FREE_BIT];
        prv_free = have_prv && heap_hdr[(prv >> 2) % WORDS][FREE_BIT];
        if (prv_free) begin
            total = int'(heap_hdr[(prv >> 2) % WORDS][23:0]) + sz;
            if (nxt_free) total += int'(heap_hdr[(nxt >> 2) % WORDS][23:0]);
            heap_hdr[(prv >> 2) % WORDS] = {1'b1, 24'(total)};
        end else if (nxt_free) begin
            heap_hdr[(p >> 2) % WORDS] =
                {1'b1, 24'(sz + int'(heap_hdr[(nxt >> 2) % WORDS][23:0]))};
        end else begin
            heap_hdr[(p >> 2) % WORDS] = {1'b1, 24'(sz)};
        end
        r.status = ST_OK;
        return r;
    endfunction

    // driver: offer the oldest pending request, honoring the sender idle rate;
    // hold an offered request until it is accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_accepted) begin
            in_accepted = 1'b0;
            if (request_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= request_fifo[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // predict on each accepted request and retire it from the queue
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (i_in_data.mode == MODE_ALLOC)
                expected_results.push_back(heap_alloc(i_in_data.request_bytes));
            else
                expected_results.push_back(heap_release(i_in_data.free_offset));
            void'(request_fifo.pop_front());
            in_accepted = 1'b1;
        end
    end

    // receiver stall: random rate, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result offset=%0d status=%0d",
                       o_out_data.data_offset, o_out_data.status);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_data.data_offset !== exp_r.data_offset) begin
                    $error("data_offset: expected %0d, got %0d",
                           exp_r.data_offset, o_out_data.data_offset);
                    error_count++;
                end
                if (o_out_data.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d",
                           exp_r.status, o_out_data.status);
                    error_count++;
                end
            end
        end
    end

    task automatic push_alloc(int nbytes);
        t_req q;
        q.mode = MODE_ALLOC;
        q.request_bytes = 13'(nbytes);
        q.free_offset = 12'($urandom);
        request_fifo.push_back(q);
    endtask

    task automatic push_free(int off);
        t_req q;
        q.mode = MODE_FREE;
        q.request_bytes = 13'($urandom);
        q.free_offset = 12'(off);
        request_fifo.push_back(q);
    endtask

    // hold until every request is sent and answered, then let the block settle
    task automatic drain();
        while (request_fifo.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_slack(logic [7:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * REG_SPLIT_SLACK);
        pwdata <= {24'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        slack_bytes = val;
    endtask

    // random mix: mostly modest allocations and frees at plausible chunk offsets
    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) push_alloc($urandom_range(1, 200));
            else if (pick < 50) push_alloc($urandom_range(0, 4096));
            else if (pick < 53) push_alloc($urandom_range(0, 8191));
            else if (pick < 90) push_free(8 + 4 * $urandom_range(0, 200));
            else push_free($urandom_range(0, 4095));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        in_accepted = 1'b0;
        heap_reset();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: size extremes, exact fit, invalid frees, coalescing
        push_alloc(0);
        push_alloc(4096);
        push_alloc(8191);
        push_alloc(1);
        push_alloc(3);
        push_alloc(100);
        push_free(8);
        push_free(8);
        push_free(4095);
        push_free(0);
        push_alloc(2);
        push_free(24);
        push_free(8);
        push_free(20);
        push_alloc(4088);
        push_free(8);
        push_alloc(4085);
        push_free(8);
        drain();

        // extremes of split_slack
        write_slack(8'd0);
        push_alloc(10); push_alloc(10); push_free(8); push_alloc(2);
        random_phase(150);
        drain();
        write_slack(8'd255);
        send_idle_pct = 61;
        random_phase(150);
        drain();
        write_slack(8'd16);
        send_idle_pct = 0;
        stall_pct = 61;
        random_phase(150);
        drain();

        // long receiver hold-off so the block backs up
        write_slack(8'(SLACK_RESET));
        stall_pct = 8;
        send_idle_pct = 8;
        hold_cycles = 3000;
        random_phase(170);
        drain();

        if (error_count == 0) begin
            $display("best_fit_heap_allocator regression: pass");
        end else begin
            $display("best_fit_heap_allocator regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
